### sv/tcpt_pkg.sv
// Package for the passive TCP connection tracker: sizes, status codes,
// connection states and reply flag constants. No dependencies.
`default_nettype none
package tcpt_pkg;
    localparam int CONNECTIONS = 8;
    localparam int SLOT_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int CNT_W = $clog2(CONNECTIONS + 1);

    localparam logic [15:0] LISTEN_PORT_RST = 16'd1234;
    localparam logic [31:0] INIT_SEQ_RST = 32'd11042000;

    localparam logic [7:0] FL_SYNACK = 8'h12;
    localparam logic [7:0] FL_ACK = 8'h10;
    localparam logic [7:0] FL_FINACK = 8'h11;
    localparam logic [7:0] FL_NONE = 8'h00;
    localparam int FL_SYN_BIT = 1;
    localparam int FL_FIN_BIT = 0;
    localparam logic [31:0] EXIT_WORD = 32'h65786974;

    localparam logic REG_LISTEN_PORT = 1'b0;
    localparam logic REG_INIT_SEQ = 1'b1;

    typedef enum logic [3:0] {
        ST_SYNACK = 4'd0, ST_ECHO = 4'd1, ST_FINACK = 4'd2, ST_CLOSED = 4'd3,
        ST_ESTAB = 4'd4, ST_WRONGPORT = 4'd5, ST_NOTSYN = 4'd6, ST_FULL = 4'd7,
        ST_BADACK = 4'd8, ST_IGNORED = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        CS_SYNRCVD = 2'd0, CS_ESTAB = 2'd1, CS_FINWAIT = 2'd2, CS_UNUSED = 2'd3
    } t_conn;

    // one memory word per slot
    typedef struct packed {
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        t_conn       conn_state;
        logic [31:0] send_seq;
        logic [31:0] recv_next;
    } t_entry;
endpackage
`default_nettype wire

### sv/tcp_passive_connection_tracker.sv
// Top level of the passive TCP connection tracker: control sequencer and
// connection table memory. Depends on tcpt_pkg.
`default_nettype none
// One segment summary in, one result out. The connection table sits in a
// synchronous memory (one word per slot, registered read port) beside a
// flip-flop valid bit per slot that reset clears, so no clearing pass is
// needed. From acceptance until its result is shown, a segment passes
// through the sequencer, which sweeps the slots one memory read per cycle
// to find the peer, reads the matched slot again, then decides and writes
// back in the execute state. The free slot is found from the valid bits.
// A result waits in an output register; the next segment is accepted once
// the previous result has been taken or as it is taken. Only one segment is
// in the table logic at a time, so reads and writes never overlap.
// Configuration writes (index 0 listen port, index 1 initial send
// sequence) take effect at once and must come while the block is idle.
module tcp_passive_connection_tracker
    import tcpt_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // src_ip[31:0], src_port[47:32], dst_port[63:48], seq_num[95:64],
    // ack_num[127:96], tcp_flags[135:128], tcp_length[151:136],
    // header_words[155:152], payload_head[187:156], zero [191:188]
    input  wire logic [191:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[3:0], reply_flags[11:4], reply_seq[43:12], reply_ack[75:44],
    // reply_ip[107:76], reply_port[123:108], echo_length[139:124],
    // conn_slot[142:140], zero [143]
    output logic [143:0]      m_axis_tdata
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_WAIT, S_EXEC} t_fsm;

    t_fsm r_fsm;
    logic [15:0] r_listen_port;
    logic [31:0] r_init_seq;
    logic [CONNECTIONS-1:0] r_valid;
    t_entry r_mem [CONNECTIONS];
    t_entry r_rd;
    logic [191:0] r_in;
    logic [CNT_W-1:0] r_idx;       // slot whose read is issued
    logic r_rd_live;                // r_rd holds slot r_idx-1 during scan
    logic r_hit;
    logic [SLOT_W-1:0] r_slot;
    logic [143:0] r_out;
    logic r_out_v;

    // field views of the held segment
    logic [31:0] w_sip, w_seq, w_ack, w_head;
    logic [15:0] w_sport, w_dport, w_tlen;
    logic [7:0]  w_flags;
    logic [3:0]  w_hw;
    assign w_sip = r_in[31:0];
    assign w_sport = r_in[47:32];
    assign w_dport = r_in[63:48];
    assign w_seq = r_in[95:64];
    assign w_ack = r_in[127:96];
    assign w_flags = r_in[135:128];
    assign w_tlen = r_in[151:136];
    assign w_hw = r_in[155:152];
    assign w_head = r_in[187:156];

    // lowest free slot from the valid bits
    logic w_free_ok;
    logic [SLOT_W-1:0] w_free;
    always_comb begin
        w_free_ok = 1'b0;
        w_free = '0;
        for (int i = CONNECTIONS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_ok = 1'b1;
                w_free = SLOT_W'(i);
            end
        end
    end

    logic [SLOT_W-1:0] w_prev;
    assign w_prev = SLOT_W'(r_idx - CNT_W'(1));

    logic w_match;
    assign w_match = r_rd_live && r_valid[w_prev] && r_rd.peer_ip == w_sip
                     && r_rd.peer_port == w_sport;

    // payload length and decision for the execute cycle
    logic [16:0] w_plen;
    logic w_has_pl;
    assign w_plen = {1'b0, w_tlen} - {11'd0, w_hw, 2'b00};
    assign w_has_pl = ({1'b0, w_tlen} > {11'd0, w_hw, 2'b00});

    t_status w_st;
    logic [7:0] w_fl;
    logic [31:0] w_rseq, w_rack;
    logic [15:0] w_elen;
    logic w_reply, w_wr, w_set_v, w_clr_v;
    t_entry w_new;
    logic [SLOT_W-1:0] w_oslot;

    always_comb begin
        w_st = ST_IGNORED;
        w_fl = FL_NONE;
        w_rseq = '0;
        w_rack = '0;
        w_elen = '0;
        w_reply = 1'b0;
        w_wr = 1'b0;
        w_set_v = 1'b0;
        w_clr_v = 1'b0;
        w_new = r_rd;
        w_oslot = r_slot;
        if (w_dport != r_listen_port) begin
            w_st = ST_WRONGPORT;
            w_oslot = '0;
        end else if (!r_hit) begin
            w_oslot = '0;
            if (!w_flags[FL_SYN_BIT]) begin
                w_st = ST_NOTSYN;
            end else if (!w_free_ok) begin
                w_st = ST_FULL;
            end else begin
                // take the free slot and answer with SYN-ACK
                w_oslot = w_free;
                w_st = ST_SYNACK;
                w_fl = FL_SYNACK;
                w_reply = 1'b1;
                w_wr = 1'b1;
                w_set_v = 1'b1;
                w_new.peer_ip = w_sip;
                w_new.peer_port = w_sport;
                w_new.conn_state = CS_SYNRCVD;
                w_new.send_seq = r_init_seq;
                w_new.recv_next = w_seq + 32'd1;
                w_rseq = r_init_seq;
                w_rack = w_seq + 32'd1;
            end
        end else begin
            unique case (r_rd.conn_state)
                CS_SYNRCVD: begin
                    if (w_ack != r_rd.send_seq + 32'd1) begin
                        w_st = ST_BADACK;
                    end else begin
                        w_st = ST_ESTAB;
                        w_wr = 1'b1;
                        w_new.conn_state = CS_ESTAB;
                        w_new.send_seq = r_rd.send_seq + 32'd1;
                    end
                end
                CS_ESTAB: begin
                    if (w_ack != r_rd.send_seq) begin
                        w_st = ST_BADACK;
                    end else if (w_flags[FL_FIN_BIT] || !w_has_pl) begin
                        w_st = ST_IGNORED;
                    end else begin
                        w_wr = 1'b1;
                        w_reply = 1'b1;
                        w_new.recv_next = r_rd.recv_next + {16'd0, w_plen[15:0]};
                        w_rseq = r_rd.send_seq;
                        w_rack = w_new.recv_next;
                        if (w_plen >= 17'd4 && w_head == EXIT_WORD) begin
                            w_st = ST_FINACK;
                            w_fl = FL_FINACK;
                            w_new.conn_state = CS_FINWAIT;
                            w_new.send_seq = r_rd.send_seq + 32'd1;
                        end else begin
                            w_st = ST_ECHO;
                            w_fl = FL_ACK;
                            w_elen = w_plen[15:0];
                            w_new.send_seq = r_rd.send_seq + {16'd0, w_plen[15:0]};
                        end
                    end
                end
                CS_FINWAIT: begin
                    if (w_flags[FL_FIN_BIT]) begin
                        // last ACK, free the slot
                        w_st = ST_CLOSED;
                        w_fl = FL_ACK;
                        w_reply = 1'b1;
                        w_clr_v = 1'b1;
                        w_rseq = r_rd.send_seq;
                        w_rack = r_rd.recv_next + 32'd1;
                    end
                end
                default: w_st = ST_IGNORED;
            endcase
        end
    end

    // accept while idle and the output register is free or being emptied
    assign s_axis_tready = (r_fsm == S_IDLE) && (!r_out_v || m_axis_tready);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = r_out;

    // memory: one write port, one registered read port; hold the matched
    // slot address through the wait cycle so the word is there to execute
    logic [SLOT_W-1:0] w_raddr;
    assign w_raddr = (r_fsm == S_READ || r_fsm == S_WAIT) ? r_slot : SLOT_W'(r_idx);
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_raddr];
        if (r_fsm == S_EXEC && w_wr) begin
            r_mem[w_oslot] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
            r_listen_port <= LISTEN_PORT_RST;
            r_init_seq <= INIT_SEQ_RST;
            r_valid <= '0;
            r_out_v <= 1'b0;
            r_idx <= '0;
            r_rd_live <= 1'b0;
            r_hit <= 1'b0;
            r_slot <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_LISTEN_PORT: r_listen_port <= i_cfg_data[15:0];
                    REG_INIT_SEQ:    r_init_seq <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tready && r_fsm != S_EXEC) begin
                r_out_v <= 1'b0;
            end
            unique case (r_fsm)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_in <= s_axis_tdata;
                        r_idx <= '0;
                        r_rd_live <= 1'b0;
                        r_hit <= 1'b0;
                        r_fsm <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // sweep slots; match on the word read last cycle
                    if (w_match && !r_hit) begin
                        r_hit <= 1'b1;
                        r_slot <= w_prev;
                    end
                    r_rd_live <= 1'b1;
                    if (r_idx == CNT_W'(CONNECTIONS)) begin
                        r_fsm <= S_READ;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_READ: r_fsm <= S_WAIT;
                S_WAIT: r_fsm <= S_EXEC;
                S_EXEC: begin
                    if (w_set_v) r_valid[w_oslot] <= 1'b1;
                    if (w_clr_v) r_valid[w_oslot] <= 1'b0;
                    r_out <= {1'b0, w_oslot, w_elen,
                              w_reply ? w_sport : 16'd0,
                              w_reply ? w_sip : 32'd0,
                              w_rack, w_rseq, w_fl, w_st};
                    r_out_v <= 1'b1;
                    r_fsm <= S_IDLE;
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // the sequencer never overwrites a result not yet taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_EXEC) |-> (!r_out_v || m_axis_tready))
        else $error("result overrun");
    // a new slot is only taken when it was free
    a_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_EXEC && w_set_v) |-> !r_valid[w_oslot])
        else $error("slot taken twice");
    // a hit always points at a valid slot
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_EXEC && r_hit) |-> r_valid[r_slot])
        else $error("hit on free slot");
`endif
endmodule
`default_nettype wire
